@@ rtl/cbc_pkg.sv @@
// Shared constants, types and command struct for the color blob centroid block.
// Used by every RTL file of the block; depends on nothing.
package cbc_pkg;

    localparam int NUM_CHAN  = 3;
    localparam int COL_W     = 10;
    localparam int ROW_W     = 9;
    localparam int LEVEL_W   = 8;
    localparam int COL_SUM_W = 30;
    localparam int ROW_SUM_W = 29;
    localparam int COUNT_W   = 20;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [LEVEL_W-1:0] THRESH_RESET = 8'd230;

    // Coordinate limits; a pixel at or beyond them counts for no channel.
    localparam int LIMIT_W  = 13;
    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 512;

    // The divider runs one quotient bit per cycle over the widest dividend.
    localparam int DIV_W     = COL_SUM_W;
    localparam int DIV_STEPS = DIV_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Configuration port.
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int IDX_LSB = 2;
    localparam logic [ADDR_W-IDX_LSB-1:0] REG_LEVEL_THRESHOLD = 1'b0;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIVIDE,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic accum;    // a pixel word is taken this cycle
        logic snap;     // that word closes the frame
        logic step;     // advance the dividers by one bit
        logic publish;  // load the held centroids into the result
    } dp_cmd_t;

endpackage

@@ rtl/cbc_ifs.sv @@
// Handshake interfaces for the pixel input channel and the centroid result channel.
// Depends on cbc_pkg for field widths.
interface cbc_pixel_if;
    logic                         valid;
    logic                         ready;
    logic [cbc_pkg::COL_W-1:0]    pixel_col;
    logic [cbc_pkg::ROW_W-1:0]    pixel_row;
    logic [cbc_pkg::LEVEL_W-1:0]  red_level;
    logic [cbc_pkg::LEVEL_W-1:0]  green_level;
    logic [cbc_pkg::LEVEL_W-1:0]  blue_level;
    logic                         frame_end;

    modport source (
        output valid, pixel_col, pixel_row, red_level, green_level, blue_level, frame_end,
        input  ready
    );
    modport sink (
        input  valid, pixel_col, pixel_row, red_level, green_level, blue_level, frame_end,
        output ready
    );
endinterface

interface cbc_result_if;
    logic                      valid;
    logic                      ready;
    logic [cbc_pkg::COL_W-1:0] red_cx;
    logic [cbc_pkg::ROW_W-1:0] red_cy;
    logic [cbc_pkg::COL_W-1:0] green_cx;
    logic [cbc_pkg::ROW_W-1:0] green_cy;
    logic [cbc_pkg::COL_W-1:0] blue_cx;
    logic [cbc_pkg::ROW_W-1:0] blue_cy;
    logic                      red_found;
    logic                      green_found;
    logic                      blue_found;

    modport source (
        output valid, red_cx, red_cy, green_cx, green_cy, blue_cx, blue_cy,
               red_found, green_found, blue_found,
        input  ready
    );
    modport sink (
        input  valid, red_cx, red_cy, green_cx, green_cy, blue_cx, blue_cy,
               red_found, green_found, blue_found,
        output ready
    );
endinterface

@@ rtl/cbc_div.sv @@
// Restoring divider, one quotient bit per step, driven by load and step strobes.
// Depends on cbc_pkg for the dividend and divisor widths.
module cbc_div (
    input  logic                          clk,
    input  logic                          load,
    input  logic                          step,
    input  logic [cbc_pkg::DIV_W-1:0]     dividend,
    input  logic [cbc_pkg::COUNT_W-1:0]   divisor,
    output logic [cbc_pkg::DIV_W-1:0]     quotient
);

    logic [cbc_pkg::DIV_W-1:0]   quo_reg, quo_next;
    logic [cbc_pkg::COUNT_W-1:0] rem_reg, rem_next;
    logic [cbc_pkg::COUNT_W-1:0] den_reg, den_next;
    logic [cbc_pkg::COUNT_W:0]   rem_shift;
    logic [cbc_pkg::COUNT_W-1:0] rem_diff;
    logic                        fits;

    always_comb
    begin
        // The remainder stays below the divisor, so the difference fits in COUNT_W bits.
        rem_shift = {rem_reg, quo_reg[cbc_pkg::DIV_W-1]};
        rem_diff  = rem_shift[cbc_pkg::COUNT_W-1:0] - den_reg;
        fits      = rem_shift >= {1'b0, den_reg};

        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (load)
        begin
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
        end
        else if (step)
        begin
            quo_next = {quo_reg[cbc_pkg::DIV_W-2:0], fits};
            rem_next = fits ? rem_diff : rem_shift[cbc_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;

endmodule

@@ rtl/cbc_datapath.sv @@
// Per-channel threshold test, sum and count accumulators, frame-end dividers
// and held centroids. Depends on cbc_pkg and cbc_div.
module cbc_datapath #(
    parameter int MAX_COLS = cbc_pkg::MAX_COLS,
    parameter int MAX_ROWS = cbc_pkg::MAX_ROWS
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  cbc_pkg::dp_cmd_t                                 cmd,
    input  logic [cbc_pkg::LEVEL_W-1:0]                      threshold,
    input  logic [cbc_pkg::COL_W-1:0]                        pixel_col,
    input  logic [cbc_pkg::ROW_W-1:0]                        pixel_row,
    input  logic [cbc_pkg::NUM_CHAN-1:0][cbc_pkg::LEVEL_W-1:0] levels,
    output logic [cbc_pkg::NUM_CHAN-1:0][cbc_pkg::COL_W-1:0] centroid_col,
    output logic [cbc_pkg::NUM_CHAN-1:0][cbc_pkg::ROW_W-1:0] centroid_row,
    output logic [cbc_pkg::NUM_CHAN-1:0]                     found
);

    localparam int NC = cbc_pkg::NUM_CHAN;

    logic [NC-1:0][cbc_pkg::COL_SUM_W-1:0] col_sum_reg, col_sum_next, col_acc;
    logic [NC-1:0][cbc_pkg::ROW_SUM_W-1:0] row_sum_reg, row_sum_next, row_acc;
    logic [NC-1:0][cbc_pkg::COUNT_W-1:0]   count_reg, count_next, count_acc;
    logic [NC-1:0][cbc_pkg::COL_W-1:0]     held_col_reg, held_col_next;
    logic [NC-1:0][cbc_pkg::ROW_W-1:0]     held_row_reg, held_row_next;
    logic [NC-1:0]                         found_snap_reg, found_snap_next;
    logic [NC-1:0]                         found_out_reg, found_out_next;
    logic [NC-1:0][cbc_pkg::DIV_W-1:0]     col_quo, row_quo;
    logic [NC-1:0]                         hit;
    logic                                  in_range;

    assign in_range = (cbc_pkg::LIMIT_W'(pixel_col) < cbc_pkg::LIMIT_W'(MAX_COLS))
                   && (cbc_pkg::LIMIT_W'(pixel_row) < cbc_pkg::LIMIT_W'(MAX_ROWS));

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            // A saturated count freezes the channel so its sums stay consistent.
            hit[c] = cmd.accum && in_range && (levels[c] > threshold)
                  && (count_reg[c] != cbc_pkg::COUNT_MAX);
            col_acc[c]   = col_sum_reg[c] + (hit[c] ? cbc_pkg::COL_SUM_W'(pixel_col) : '0);
            row_acc[c]   = row_sum_reg[c] + (hit[c] ? cbc_pkg::ROW_SUM_W'(pixel_row) : '0);
            count_acc[c] = count_reg[c] + cbc_pkg::COUNT_W'(hit[c]);

            col_sum_next[c]    = cmd.snap ? '0 : col_acc[c];
            row_sum_next[c]    = cmd.snap ? '0 : row_acc[c];
            count_next[c]      = cmd.snap ? '0 : count_acc[c];
            found_snap_next[c] = cmd.snap ? (count_acc[c] != '0) : found_snap_reg[c];

            held_col_next[c]  = held_col_reg[c];
            held_row_next[c]  = held_row_reg[c];
            found_out_next[c] = found_out_reg[c];
            if (cmd.publish)
            begin
                found_out_next[c] = found_snap_reg[c];
                if (found_snap_reg[c])
                begin
                    held_col_next[c] = col_quo[c][cbc_pkg::COL_W-1:0];
                    held_row_next[c] = row_quo[c][cbc_pkg::ROW_W-1:0];
                end
            end
        end
    end

    for (genvar g = 0; g < NC; g++)
    begin : g_chan
        cbc_div u_col_div (
            .clk      (clk),
            .load     (cmd.snap),
            .step     (cmd.step),
            .dividend (col_acc[g]),
            .divisor  (count_acc[g]),
            .quotient (col_quo[g])
        );

        cbc_div u_row_div (
            .clk      (clk),
            .load     (cmd.snap),
            .step     (cmd.step),
            .dividend (cbc_pkg::DIV_W'(row_acc[g])),
            .divisor  (count_acc[g]),
            .quotient (row_quo[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_sum_reg    <= '0;
            row_sum_reg    <= '0;
            count_reg      <= '0;
            held_col_reg   <= '0;
            held_row_reg   <= '0;
            found_snap_reg <= '0;
            found_out_reg  <= '0;
        end
        else
        begin
            col_sum_reg    <= col_sum_next;
            row_sum_reg    <= row_sum_next;
            count_reg      <= count_next;
            held_col_reg   <= held_col_next;
            held_row_reg   <= held_row_next;
            found_snap_reg <= found_snap_next;
            found_out_reg  <= found_out_next;
        end
    end

    assign centroid_col = held_col_reg;
    assign centroid_row = held_row_reg;
    assign found        = found_out_reg;

endmodule

@@ rtl/cbc_ctrl.sv @@
// Controller: accumulate, divide and publish phases plus the result valid flag.
// Depends on cbc_pkg for the state and command types.
module cbc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output cbc_pkg::dp_cmd_t cmd
);

    cbc_pkg::state_t             state_reg, state_next;
    logic [cbc_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        last_step;

    assign last_step = step_reg == cbc_pkg::STEP_W'(cbc_pkg::DIV_STEPS - 1);

    // Outputs and commands.
    always_comb
    begin
        in_ready    = state_reg == cbc_pkg::ST_ACCUM;
        cmd.accum   = in_valid && in_ready;
        cmd.snap    = cmd.accum && in_last;
        cmd.step    = state_reg == cbc_pkg::ST_DIVIDE;
        cmd.publish = (state_reg == cbc_pkg::ST_PUBLISH) && (!out_valid_reg || out_ready);

        step_next = cmd.step ? step_reg + 1'b1 : '0;

        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cbc_pkg::ST_ACCUM:
            begin
                if (cmd.snap)
                begin
                    state_next = cbc_pkg::ST_DIVIDE;
                end
            end
            cbc_pkg::ST_DIVIDE:
            begin
                if (last_step)
                begin
                    state_next = cbc_pkg::ST_PUBLISH;
                end
            end
            cbc_pkg::ST_PUBLISH:
            begin
                if (cmd.publish)
                begin
                    state_next = cbc_pkg::ST_ACCUM;
                end
            end
            default:
            begin
                state_next = cbc_pkg::ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cbc_pkg::ST_ACCUM;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/color_blob_centroid_core.sv @@
// Color blob centroid core: one pixel word per cycle while a frame streams in.
// The frame-end word is accumulated, then bit-serial division in the ST_DIVIDE
// state (one quotient bit per cycle in six parallel dividers) and a publish
// follow; the publish sets the registered result valid flag, and input is
// held off until the publish, longer if an earlier result is still waiting. Reset
// (rst_n, asynchronous) clears sums, counts, held centroids; threshold returns to 230.
module color_blob_centroid_core #(
    parameter int MAX_COLS = cbc_pkg::MAX_COLS,
    parameter int MAX_ROWS = cbc_pkg::MAX_ROWS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbc_pkg::ADDR_W-1:0]    paddr,
    input  logic [cbc_pkg::DATA_W-1:0]    pwdata,
    output logic [cbc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    cbc_pixel_if.sink                     pixel,
    cbc_result_if.source                  result
);

    localparam int NC = cbc_pkg::NUM_CHAN;

    logic [cbc_pkg::LEVEL_W-1:0]          threshold_reg, threshold_next;
    logic                                 reg_sel;
    cbc_pkg::dp_cmd_t                     cmd;
    logic [NC-1:0][cbc_pkg::LEVEL_W-1:0]  levels;
    logic [NC-1:0][cbc_pkg::COL_W-1:0]    centroid_col;
    logic [NC-1:0][cbc_pkg::ROW_W-1:0]    centroid_row;
    logic [NC-1:0]                        found;

    // Configuration register.
    assign pready  = 1'b1;
    assign reg_sel = paddr[cbc_pkg::ADDR_W-1:cbc_pkg::IDX_LSB] == cbc_pkg::REG_LEVEL_THRESHOLD;

    always_comb
    begin
        threshold_next = threshold_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            threshold_next = pwdata[cbc_pkg::LEVEL_W-1:0];
        end
        prdata = reg_sel ? cbc_pkg::DATA_W'(threshold_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= cbc_pkg::THRESH_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    assign levels = {pixel.blue_level, pixel.green_level, pixel.red_level};

    cbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_last   (pixel.frame_end),
        .in_ready  (pixel.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    cbc_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .threshold    (threshold_reg),
        .pixel_col    (pixel.pixel_col),
        .pixel_row    (pixel.pixel_row),
        .levels       (levels),
        .centroid_col (centroid_col),
        .centroid_row (centroid_row),
        .found        (found)
    );

    assign result.red_cx      = centroid_col[0];
    assign result.red_cy      = centroid_row[0];
    assign result.green_cx    = centroid_col[1];
    assign result.green_cy    = centroid_row[1];
    assign result.blue_cx     = centroid_col[2];
    assign result.blue_cy     = centroid_row[2];
    assign result.red_found   = found[0];
    assign result.green_found = found[1];
    assign result.blue_found  = found[2];

endmodule
